>>> design/mie_pkg.sv
// ----------------------------------------------------------------------------
// mie_pkg
// Shared constants and types of the modular inverse block.
// ----------------------------------------------------------------------------
package mie_pkg;

   localparam int WORD_BITS_DEFAULT = 30;

   // reset value of the modulus register
   localparam logic [63:0] DEFAULT_MODULUS = 64'd998244353;

   // register byte addresses
   localparam logic [2:0] REG_MODULUS = 3'd0;

   // datapath operations
   typedef enum logic [2:0] {
      OP_NOP,
      OP_LOAD,    // take value and modulus, seed coefficients
      OP_STEP,    // set up the division of one Euclid step
      OP_ALIGN,   // double divisor and coefficient
      OP_SUB,     // conditional subtract, halve or close the step
      OP_ABS,     // split coefficient into sign and magnitude
      OP_RED,     // bring magnitude below the modulus
      OP_FIN      // form the inverse and the gcd
   } op_type;

   typedef struct packed {
      op_type op;
      logic   out_load;   // move the finished result into the output register
   } cmd_type;

   typedef struct packed {
      logic r1_zero;      // divisor of the next step is zero: gcd found
      logic can_double;   // doubled divisor still fits the remainder
      logic k_zero;       // shift count back at zero
   } status_type;

endpackage

>>> design/mie_datapath.sv
// ----------------------------------------------------------------------------
// mie_datapath
// Extended Euclid datapath: shift-subtract division with coefficient update.
// ----------------------------------------------------------------------------
module mie_datapath #(
   parameter int WORD_BITS = mie_pkg::WORD_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mie_pkg::cmd_type       cmd,
   input  logic [WORD_BITS-1:0]   value,
   input  logic [WORD_BITS-1:0]   modulus,
   output mie_pkg::status_type    status,
   output logic [WORD_BITS-1:0]   inverse,
   output logic [WORD_BITS-1:0]   common_divisor
);

   localparam int SW = WORD_BITS + 3;          // signed coefficient width
   localparam int DW = WORD_BITS + 1;          // shifted divisor width
   localparam int KW = $clog2(WORD_BITS + 1);  // shift count width

   logic [WORD_BITS-1:0]  r0_ff, r1_ff, rem_ff, m_ff, inv_ff, gcd_ff;
   logic signed [SW-1:0]  s0_ff, s1_ff, s_acc_ff, t_sh_ff;
   logic [DW-1:0]         d_sh_ff;
   logic [KW-1:0]         k_ff;
   logic                  neg_ff;
   logic [WORD_BITS:0]    mag_ff;

   logic                  fits;
   logic [WORD_BITS-1:0]  rem_n;
   logic signed [SW-1:0]  s_n;
   logic signed [SW-1:0]  s0_neg;
   logic [WORD_BITS:0]    mag_abs;
   logic [WORD_BITS:0]    mag_red;
   logic [WORD_BITS-1:0]  inv_in;

   assign fits   = d_sh_ff <= {1'b0, rem_ff};
   assign rem_n  = fits ? (rem_ff - d_sh_ff[WORD_BITS-1:0]) : rem_ff;
   assign s_n    = fits ? (s_acc_ff - t_sh_ff) : s_acc_ff;
   assign s0_neg = -s0_ff;
   assign mag_abs = s0_ff[SW-1] ? s0_neg[WORD_BITS:0] : s0_ff[WORD_BITS:0];
   assign mag_red = (mag_ff >= {1'b0, m_ff}) ? (mag_ff - {1'b0, m_ff}) : mag_ff;

   always_comb begin
      if (m_ff == '0) begin
         inv_in = '0;
      end else if (neg_ff && (mag_ff != '0)) begin
         inv_in = m_ff - mag_ff[WORD_BITS-1:0];
      end else begin
         inv_in = mag_ff[WORD_BITS-1:0];
      end
   end

   assign status.r1_zero    = (r1_ff == '0);
   assign status.can_double = {d_sh_ff, 1'b0} <= {2'b00, rem_ff};
   assign status.k_zero     = (k_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
      end else begin
         unique case (cmd.op)
            mie_pkg::OP_NOP: begin
            end
            mie_pkg::OP_LOAD: begin
               r0_ff <= value;
               r1_ff <= modulus;
               m_ff  <= modulus;
               s0_ff <= SW'(1);
               s1_ff <= '0;
            end
            mie_pkg::OP_STEP: begin
               rem_ff   <= r0_ff;
               d_sh_ff  <= {1'b0, r1_ff};
               t_sh_ff  <= s1_ff;
               s_acc_ff <= s0_ff;
               k_ff     <= '0;
            end
            mie_pkg::OP_ALIGN: begin
               d_sh_ff <= {d_sh_ff[DW-2:0], 1'b0};
               t_sh_ff <= t_sh_ff <<< 1;
               k_ff    <= k_ff + KW'(1);
            end
            mie_pkg::OP_SUB: begin
               if (k_ff == '0) begin
                  r0_ff <= r1_ff;
                  r1_ff <= rem_n;
                  s0_ff <= s1_ff;
                  s1_ff <= s_n;
               end else begin
                  rem_ff   <= rem_n;
                  s_acc_ff <= s_n;
                  d_sh_ff  <= d_sh_ff >> 1;
                  t_sh_ff  <= t_sh_ff >>> 1;
                  k_ff     <= k_ff - KW'(1);
               end
            end
            mie_pkg::OP_ABS: begin
               neg_ff <= s0_ff[SW-1];
               mag_ff <= mag_abs;
            end
            mie_pkg::OP_RED: begin
               mag_ff <= mag_red;
            end
            mie_pkg::OP_FIN: begin
               inv_ff <= inv_in;
               gcd_ff <= r0_ff;
            end
            default: begin
            end
         endcase
      end
   end

   assign inverse        = inv_ff;
   assign common_divisor = gcd_ff;

   // shift count never passes the word width
   a_k_range: assert property (@(posedge clock) disable iff (reset)
      k_ff <= KW'(WORD_BITS))
      else $error("shift count out of range");

   // doubling only ever happens while the divisor still fits the remainder
   a_align_fits: assert property (@(posedge clock) disable iff (reset)
      cmd.op == mie_pkg::OP_ALIGN |=> d_sh_ff <= {1'b0, rem_ff})
      else $error("aligned divisor exceeds remainder");

   // closing a step leaves a remainder below the divisor
   a_step_shrinks: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == mie_pkg::OP_SUB && k_ff == '0) |=> r1_ff < r0_ff)
      else $error("Euclid remainder did not shrink");

endmodule

>>> design/mie_ctrl.sv
// ----------------------------------------------------------------------------
// mie_ctrl
// Sequencer for the extended Euclid datapath.
// ----------------------------------------------------------------------------
module mie_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_fire,
   input  logic                out_free,
   input  mie_pkg::status_type status,
   output logic                idle,
   output mie_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_STEP,
      S_ALIGN,
      S_SUB,
      S_RED,
      S_FIN,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in     = state_ff;
      cmd.op       = mie_pkg::OP_NOP;
      cmd.out_load = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd.op   = mie_pkg::OP_LOAD;
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            if (status.r1_zero) begin
               cmd.op   = mie_pkg::OP_ABS;
               state_in = S_RED;
            end else begin
               cmd.op   = mie_pkg::OP_STEP;
               state_in = S_ALIGN;
            end
         end
         S_ALIGN: begin
            if (status.can_double) begin
               cmd.op = mie_pkg::OP_ALIGN;
            end else begin
               // first subtract at the top alignment
               cmd.op   = mie_pkg::OP_SUB;
               state_in = status.k_zero ? S_STEP : S_SUB;
            end
         end
         S_SUB: begin
            cmd.op = mie_pkg::OP_SUB;
            if (status.k_zero) begin
               state_in = S_STEP;
            end
         end
         S_RED: begin
            cmd.op   = mie_pkg::OP_RED;
            state_in = S_FIN;
         end
         S_FIN: begin
            cmd.op   = mie_pkg::OP_FIN;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign idle = (state_ff == S_IDLE);

endmodule

>>> design/modular_inverse_ext_euclid.sv
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid
// Modular inverse and gcd by the extended Euclidean algorithm.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: one request carries a value (req_tdata). Accepted when
//    req_tvalid and req_tready are high at a clock edge. req_tready is high
//    only while no request is being worked on.
//  - rsp channel: one result per request, inverse in the low field and
//    gcd(value, modulus) above it. A gcd of 1 means the inverse is valid.
//  - csr port: APB-style, one register (modulus) at byte address 0. Write it
//    only while the block is idle. Reset value 998244353.
//  - Sequence: load, then one shift-subtract division per Euclid step in the
//    datapath, whose length grows with that step's quotient, then sign
//    fix-up and reduction, then the hand-over to the output register. One
//    request is in flight at a time.
//  - The output register parts the channels: a new request is taken while
//    the last result still waits on rsp_tready. A stalled result holds; the
//    next one waits in the controller until the register frees up.
//  - Reset clears the controller and the output valid flag and restores the
//    modulus register to its default.
// ----------------------------------------------------------------------------
module modular_inverse_ext_euclid #(
   parameter int WORD_BITS = mie_pkg::WORD_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request: [WORD_BITS-1:0] value, rest zero
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((WORD_BITS+7)/8)*8-1:0]         req_tdata,
   // response: [WORD_BITS-1:0] inverse, [2*WORD_BITS-1:WORD_BITS]
   // common_divisor, rest zero
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [((2*WORD_BITS+7)/8)*8-1:0]       rsp_tdata,
   // configuration; data is 64 bits once the modulus no longer fits 32
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [2:0]                             csr_paddr,
   input  logic [(WORD_BITS > 32 ? 64 : 32)-1:0]  csr_pwdata,
   output logic [(WORD_BITS > 32 ? 64 : 32)-1:0]  csr_prdata,
   output logic                                   csr_pready
);

   localparam int RSP_BITS = ((2*WORD_BITS+7)/8)*8;

   logic [WORD_BITS-1:0] modulus_ff;
   logic                 rsp_valid_ff;
   logic [WORD_BITS-1:0] rsp_inv_ff, rsp_gcd_ff;

   logic                 idle;
   logic                 req_fire;
   logic                 out_free;
   mie_pkg::cmd_type     cmd;
   mie_pkg::status_type  status;
   logic [WORD_BITS-1:0] dp_inverse, dp_gcd;

   // ---- configuration register ----
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= mie_pkg::DEFAULT_MODULUS[WORD_BITS-1:0];
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr == mie_pkg::REG_MODULUS) begin
         modulus_ff <= csr_pwdata[WORD_BITS-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == mie_pkg::REG_MODULUS) begin
         csr_prdata[WORD_BITS-1:0] = modulus_ff;
      end
   end

   // ---- handshakes ----
   assign req_tready = idle;
   assign req_fire   = req_tvalid && idle;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   mie_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .out_free (out_free),
      .status   (status),
      .idle     (idle),
      .cmd      (cmd)
   );

   mie_datapath #(
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .value          (req_tdata[WORD_BITS-1:0]),
      .modulus        (modulus_ff),
      .status         (status),
      .inverse        (dp_inverse),
      .common_divisor (dp_gcd)
   );

   // ---- output register ----
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_inv_ff <= dp_inverse;
         rsp_gcd_ff <= dp_gcd;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_BITS'({rsp_gcd_ff, rsp_inv_ff});

endmodule
